/* src/stack_blur_line_defines.svh */
// ----------------------------------------------------------------------------
// stack_blur_line_defines
// Assertion macros shared by the stack blur line modules.
// ----------------------------------------------------------------------------
`ifndef STACK_BLUR_LINE_DEFINES_SVH
`define STACK_BLUR_LINE_DEFINES_SVH

// property checked on every rising edge outside reset
`define SBL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never be seen outside reset
`define SBL_NEVER(lbl, cond, msg) \
	`SBL_ASSERT(lbl, !(cond), msg)

`endif

/* src/sbl_pkg.sv */
// ----------------------------------------------------------------------------
// sbl_pkg
// Types and constants shared by the stack blur line controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

	// pixel, radius register and quotient widths
	localparam int PIX_W        = 8;
	localparam int RAD_W        = 6;
	localparam int QUOT_W       = 9;
	localparam int RADIUS_RESET = 1;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START1,
		ST_START2,
		ST_RD,
		ST_CALC,
		ST_CHK,
		ST_DIVS,
		ST_DIVW,
		ST_OUT,
		ST_NEXT
	} sbl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic start1;
		logic start2;
		logic rd;
		logic calc;
		logic flush_load;
		logic flush_dec;
		logic div_start;
		logic out_load;
	} sbl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic r_zero;
		logic fill_full;
		logic last;
		logic flush_zero;
		logic div_busy;
		logic out_free;
	} sbl_stat_t;

endpackage

`default_nettype wire

/* src/sbl_ram.sv */
// ----------------------------------------------------------------------------
// sbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 66
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* src/sbl_div.sv */
// ----------------------------------------------------------------------------
// sbl_div
// Restoring divider, one quotient bit per cycle, for the blur normalization.
// The numerator must stay below the divisor times 2^QUOT_W.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_div #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [NUM_W-1:0]           num,
	input  wire logic [DEN_W-1:0]           den,
	output logic                            busy,
	output logic [sbl_pkg::QUOT_W-1:0]      quot
);

	import sbl_pkg::*;

	localparam int TR_W  = DEN_W + QUOT_W - 1;
	localparam int CMP_W = (NUM_W > TR_W) ? NUM_W : TR_W;
	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [NUM_W-1:0]  rem_q;
	logic [TR_W-1:0]   trial_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CMP_W-1:0]  rem_ext;
	logic [CMP_W-1:0]  trial_ext;
	logic              fits;

	// trial subtraction of the shifted divisor
	assign rem_ext   = CMP_W'(rem_q);
	assign trial_ext = CMP_W'(trial_q);
	assign fits      = rem_ext >= trial_ext;
	assign busy      = cnt_q != '0;
	assign quot      = quot_q;

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUOT_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// remainder, divisor and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= num;
			trial_q <= {den, {(QUOT_W - 1){1'b0}}};
			quot_q  <= '0;
		end else if (busy) begin
			if (fits) begin
				rem_q <= NUM_W'(rem_ext - trial_ext);
			end
			trial_q <= trial_q >> 1;
			quot_q  <= {quot_q[QUOT_W-2:0], fits};
		end
	end

endmodule

`default_nettype wire

/* src/sbl_ctrl.sv */
// ----------------------------------------------------------------------------
// sbl_ctrl
// Sequencer for the stack blur line: line start, window pushes, flush of the
// line tail, normalization and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_blur_line_defines.svh"

module sbl_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sbl_pkg::sbl_stat_t stat,
	output sbl_pkg::sbl_cmd_t       cmd
);

	import sbl_pkg::*;

	sbl_state_t state_q;
	sbl_state_t state_nxt;
	logic       line_start_q;
	logic       line_end;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// waiting for the first pixel of a line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q <= 1'b1;
		end else if (cmd.start1) begin
			line_start_q <= 1'b0;
		end else if (line_end) begin
			line_start_q <= 1'b1;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = line_start_q ? ST_START1 : ST_RD;
				end
			end
			ST_START1: state_nxt = ST_START2;
			ST_START2: state_nxt = stat.r_zero ? ST_DIVS : ST_NEXT;
			ST_RD:     state_nxt = ST_CALC;
			ST_CALC:   state_nxt = ST_CHK;
			ST_CHK:    state_nxt = stat.fill_full ? ST_DIVS : ST_NEXT;
			ST_DIVS:   state_nxt = ST_DIVW;
			ST_DIVW: begin
				if (!stat.div_busy) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					state_nxt = ST_NEXT;
				end
			end
			ST_NEXT: begin
				state_nxt = (stat.last && !stat.flush_zero) ? ST_RD : ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		line_end = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.accept     = in_valid;
				cmd.flush_load = in_valid && !line_start_q;
			end
			ST_START1: cmd.start1 = 1'b1;
			ST_START2: begin
				cmd.start2     = 1'b1;
				cmd.flush_load = 1'b1;
			end
			ST_RD:   cmd.rd = 1'b1;
			ST_CALC: cmd.calc = 1'b1;
			ST_CHK: begin
			end
			ST_DIVS: cmd.div_start = 1'b1;
			ST_DIVW: begin
			end
			ST_OUT:  cmd.out_load = stat.out_free;
			ST_NEXT: begin
				cmd.flush_dec = stat.last && !stat.flush_zero;
				line_end      = stat.last && stat.flush_zero;
			end
			default: begin
			end
		endcase
	end

	// checks
	`SBL_NEVER(a_out_load_free, cmd.out_load && !stat.out_free, "output loaded while full")
	`SBL_NEVER(a_div_start_idle, cmd.div_start && stat.div_busy, "divider restarted while busy")
	`SBL_ASSERT(a_line_end_last, $rose(line_start_q) |-> $past(stat.last), "line ended without last")

endmodule

`default_nettype wire

/* src/sbl_dp.sv */
// ----------------------------------------------------------------------------
// sbl_dp
// Datapath of the stack blur line: radius register, window RAM, running sums,
// divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_blur_line_defines.svh"

module sbl_dp #(
	parameter int MAX_RADIUS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [sbl_pkg::RAD_W-1:0]  cfg_wdata,
	input  wire logic [sbl_pkg::PIX_W-1:0]  in_pixel,
	input  wire logic                       in_last,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [sbl_pkg::PIX_W-1:0]       out_pixel,
	output logic                            out_last,
	input  wire sbl_pkg::sbl_cmd_t          cmd,
	output sbl_pkg::sbl_stat_t              stat
);

	import sbl_pkg::*;

	localparam int R_W    = $clog2(MAX_RADIUS + 1);
	localparam int RP1_W  = $clog2(MAX_RADIUS + 2);
	localparam int DEPTH  = 2 * MAX_RADIUS + 2;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int LW     = PTR_W + 1;
	localparam int SUM_W  = $clog2((MAX_RADIUS + 1) * 255 + 1);
	localparam int AREA_W = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1);
	localparam int WS_W   = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) * 255 + 1);
	localparam int NUM_W  = WS_W + 2;
	localparam int DEN_W  = AREA_W + 1;

	logic [RAD_W-1:0]        radius_q;
	logic [PIX_W-1:0]        pix_q;
	logic                    last_q;
	logic [PIX_W-1:0]        first_q;
	logic [R_W-1:0]          r_q;
	logic [AREA_W-1:0]       area_q;
	logic [SUM_W-1:0]        recent_q;
	logic [SUM_W-1:0]        older_q;
	logic [WS_W-1:0]         wsum_q;
	logic [PTR_W-1:0]        wp_q;
	logic                    wrapped_q;
	logic [R_W-1:0]          fill_q;
	logic [R_W-1:0]          flush_q;
	logic                    old_wr_q;
	logic                    mid_wr_q;
	logic                    done_q;
	logic                    out_valid_q;
	logic [PIX_W-1:0]        out_pix_q;
	logic                    out_last_q;

	logic [R_W-1:0]          r_sat;
	logic [RP1_W-1:0]        rp1;
	logic [2*RP1_W-1:0]      area_prod;
	logic [RP1_W+PIX_W-1:0]  line_prod;
	logic [AREA_W+PIX_W-1:0] wsum_prod;
	logic [LW-1:0]           len;
	logic [LW-1:0]           mid_sum;
	logic [PTR_W-1:0]        mid_addr;
	logic [LW-1:0]           wp_inc;
	logic [PIX_W-1:0]        rd_old;
	logic [PIX_W-1:0]        rd_mid;
	logic [PIX_W-1:0]        oldest;
	logic [PIX_W-1:0]        mid;
	logic [SUM_W-1:0]        recent_nxt;
	logic [SUM_W-1:0]        older_nxt;
	logic [WS_W-1:0]         wsum_nxt;
	logic [NUM_W-1:0]        div_num;
	logic [DEN_W-1:0]        div_den;
	logic                    div_busy;
	logic [QUOT_W-1:0]       div_quot;
	logic [PIX_W-1:0]        quot_sat;
	logic                    out_free;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_W'(RADIUS_RESET);
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// line start products
	assign r_sat     = (radius_q > RAD_W'(MAX_RADIUS)) ? R_W'(MAX_RADIUS)
	                                                   : R_W'(radius_q);
	assign rp1       = RP1_W'(r_sat) + RP1_W'(1);
	assign area_prod = (2*RP1_W)'(rp1) * (2*RP1_W)'(rp1);
	assign line_prod = (RP1_W+PIX_W)'(rp1) * (RP1_W+PIX_W)'(pix_q);
	assign wsum_prod = (AREA_W+PIX_W)'(area_q) * (AREA_W+PIX_W)'(first_q);

	// ring addressing over 2r+2 entries
	assign len      = LW'({r_q, 1'b0}) + LW'(2);
	assign mid_sum  = LW'(wp_q) + LW'(r_q) + LW'(1);
	assign mid_addr = (mid_sum >= len) ? PTR_W'(mid_sum - len) : PTR_W'(mid_sum);
	assign wp_inc   = LW'(wp_q) + LW'(1);

	// entries not yet written in this line read as the first pixel
	assign oldest = old_wr_q ? rd_old : first_q;
	assign mid    = mid_wr_q ? rd_mid : first_q;

	// running sum update
	assign recent_nxt = recent_q + SUM_W'(pix_q) - SUM_W'(mid);
	assign older_nxt  = older_q + SUM_W'(mid) - SUM_W'(oldest);
	assign wsum_nxt   = wsum_q + WS_W'(recent_nxt) - WS_W'(older_nxt);

	// input item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q  <= in_pixel;
			last_q <= in_last;
		end
	end

	// window sums and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q       <= '0;
			area_q    <= '0;
			first_q   <= '0;
			recent_q  <= '0;
			older_q   <= '0;
			wsum_q    <= '0;
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			fill_q    <= '0;
		end else if (cmd.start1) begin
			r_q       <= r_sat;
			area_q    <= AREA_W'(area_prod);
			first_q   <= pix_q;
			recent_q  <= SUM_W'(line_prod);
			older_q   <= SUM_W'(line_prod);
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			fill_q    <= '0;
		end else if (cmd.start2) begin
			wsum_q <= WS_W'(wsum_prod);
		end else if (cmd.calc) begin
			recent_q <= recent_nxt;
			older_q  <= older_nxt;
			wsum_q   <= wsum_nxt;
			if (wp_inc == len) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= PTR_W'(wp_inc);
			end
			if (fill_q < r_q) begin
				fill_q <= fill_q + R_W'(1);
			end
		end
	end

	// tail flush count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= '0;
		end else if (cmd.flush_load) begin
			flush_q <= r_q;
		end else if (cmd.flush_dec) begin
			flush_q <= flush_q - R_W'(1);
		end
	end

	// written-this-line flags for the two window reads
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			old_wr_q <= wrapped_q;
			mid_wr_q <= wrapped_q || (mid_addr < wp_q);
		end
	end

	// window copies, one per read address
	sbl_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_ram_old (
		.clk  (clk),
		.we   (cmd.calc),
		.waddr(wp_q),
		.wdata(pix_q),
		.raddr(wp_q),
		.rdata(rd_old)
	);

	sbl_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_ram_mid (
		.clk  (clk),
		.we   (cmd.calc),
		.waddr(wp_q),
		.wdata(pix_q),
		.raddr(mid_addr),
		.rdata(rd_mid)
	);

	// normalization: (2*wsum + area) / (2*area)
	assign div_num = {1'b0, wsum_q, 1'b0} + NUM_W'(area_q);
	assign div_den = {area_q, 1'b0};

	sbl_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quot  (div_quot)
	);

	// final pixel of the line marker
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			done_q <= last_q && (flush_q == '0);
		end
	end

	// output register
	assign quot_sat = (|div_quot[QUOT_W-1:PIX_W]) ? {PIX_W{1'b1}} : div_quot[PIX_W-1:0];
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pix_q  <= quot_sat;
			out_last_q <= done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pix_q;
	assign out_last  = out_last_q;

	// status to the controller
	always_comb begin
		stat            = '0;
		stat.r_zero     = r_q == '0;
		stat.fill_full  = fill_q == r_q;
		stat.last       = last_q;
		stat.flush_zero = flush_q == '0;
		stat.div_busy   = div_busy;
		stat.out_free   = out_free;
	end

	// checks
	`SBL_NEVER(a_fill_le_r, fill_q > r_q, "fill count past radius")
	`SBL_NEVER(a_wp_in_ring, LW'(wp_q) >= len, "write pointer outside ring")
	`SBL_NEVER(a_mid_in_ring, cmd.rd && (LW'(mid_addr) >= len), "middle read outside ring")

endmodule

`default_nettype wire

/* src/stack_blur_line.sv */
// ----------------------------------------------------------------------------
// stack_blur_line
// One-dimensional stack blur of a line of 8-bit pixels.
// ----------------------------------------------------------------------------
// Pixels of a line enter in order on the slave stream, tlast on the final one.
// Blurred pixel c leaves once pixel c+r has entered; the final pixel flushes
// the remaining r outputs, the last one flagged by tlast. The radius is
// written through cfg_we/cfg_wdata between lines, saturates at MAX_RADIUS and
// is latched at the first pixel of each line; radius 0 passes pixels through.
// The first pixel of a line opens the window; each further pixel gets a window
// update (registered window RAM read, then sum update), and each result then
// goes through the one-bit-per-cycle normalizing divider (9 steps) and the
// output load; the final pixel takes r extra updates. The output register
// lets the next pixel enter while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_blur_line #(
	parameter int MAX_RADIUS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration: radius
	input  wire logic                      cfg_we,
	input  wire logic [sbl_pkg::RAD_W-1:0] cfg_wdata,
	// pixel input
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [7:0]                s_axis_tdata,  // [7:0] pixel_in
	input  wire logic                      s_axis_tlast,  // last_in_line
	// blurred output
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // [7:0] pixel_out
	output logic                           m_axis_tlast   // line_done
);

	import sbl_pkg::*;

	sbl_cmd_t  cmd;
	sbl_stat_t stat;

	// sequencer
	sbl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath
	sbl_dp #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_pixel (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_pixel(m_axis_tdata),
		.out_last (m_axis_tlast),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

`default_nettype wire

/* tb/tb_stack_blur_line.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_blur_line
// Self-checking bench for the one-dimensional stack blur of a pixel line.
// ----------------------------------------------------------------------------
// Lines of pixels go in on the slave stream under several radius settings,
// from pass-through to a saturated radius. A scoreboard keeps its own copy of
// the blur state, works out every blurred pixel that a pixel request should
// release and compares each result on the master stream in order. Both
// stream sides idle at random in two of three phases, and the sender
// sometimes holds off until every pending blurred pixel has come out.
// ----------------------------------------------------------------------------

module tb_stack_blur_line;

	import sbl_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int MAX_RAD       = 32;
	localparam int WINDOW_DEPTH  = 2 * MAX_RAD + 2;
	localparam int PHASE_PIXELS  = 145;
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT   = 2000000;

	// one blurred pixel as it leaves the block
	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             done;
	} blurred_t;

	// running copy of the blur state and the queue of pending blurred pixels
	class blur_scoreboard;
		logic [RAD_W-1:0] radius;
		logic [PIX_W-1:0] window [WINDOW_DEPTH];
		logic [13:0]      recent_sum;
		logic [13:0]      older_sum;
		logic [18:0]      weighted_sum;
		int unsigned      wr_ptr;
		int unsigned      fill;
		int unsigned      active_r;
		bit               awaiting_first;
		blurred_t         expected [$];
		int               mismatches;

		function new();
			radius         = RAD_W'(RADIUS_RESET);
			recent_sum     = '0;
			older_sum      = '0;
			weighted_sum   = '0;
			wr_ptr         = 0;
			fill           = 0;
			active_r       = 0;
			awaiting_first = 1'b1;
			mismatches     = 0;
		endfunction

		function void set_radius(input logic [RAD_W-1:0] value);
			radius = value;
		endfunction

		// first pixel of a line fills the whole window
		function void open_line(input logic [PIX_W-1:0] p);
			active_r = (radius > MAX_RAD) ? MAX_RAD : radius;
			for (int i = 0; i < WINDOW_DEPTH; i++)
				window[i] = p;
			recent_sum     = 14'((active_r + 1) * p);
			older_sum      = recent_sum;
			weighted_sum   = 19'((active_r + 1) * (active_r + 1) * p);
			wr_ptr         = 0;
			fill           = 0;
			awaiting_first = 1'b0;
		endfunction

		// move the window on by one value
		function void shift_in(input logic [PIX_W-1:0] v);
			int unsigned      len;
			int unsigned      wp;
			logic [PIX_W-1:0] oldest;
			logic [PIX_W-1:0] mid;
			len          = 2 * active_r + 2;
			wp           = wr_ptr % len;
			oldest       = window[wp];
			mid          = window[(wp + active_r + 1) % len];
			recent_sum   = recent_sum + v - mid;
			older_sum    = older_sum + mid - oldest;
			weighted_sum = weighted_sum + recent_sum - older_sum;
			window[wp]   = v;
			wr_ptr       = (wp + 1) % len;
			if (fill < active_r)
				fill++;
		endfunction

		// rounded normalization of the stack sum
		function blurred_t blurred_pixel();
			int unsigned area;
			int unsigned wsum;
			int unsigned q;
			blurred_t    res;
			area = (active_r + 1) * (active_r + 1);
			wsum = weighted_sum;
			q    = (2 * wsum + area) / (2 * area);
			if (q > 255)
				q = 255;
			res.pixel = PIX_W'(q);
			res.done  = 1'b0;
			return res;
		endfunction

		// accepted pixel request: queue the blurred pixels it releases
		function void note_pixel(input logic [PIX_W-1:0] pix, input logic last);
			blurred_t produced [$];
			if (awaiting_first) begin
				open_line(pix);
				if (active_r == 0)
					produced.push_back(blurred_pixel());
			end else begin
				shift_in(pix);
				if (fill == active_r)
					produced.push_back(blurred_pixel());
			end
			// the last pixel flushes the rest of the line
			if (last) begin
				for (int t = 0; t < active_r; t++) begin
					shift_in(pix);
					if (fill == active_r)
						produced.push_back(blurred_pixel());
				end
				if (produced.size() > 0)
					produced[produced.size() - 1].done = 1'b1;
				awaiting_first = 1'b1;
			end
			foreach (produced[i])
				expected.push_back(produced[i]);
		endfunction

		task report_mismatch(input string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		// accepted result: compare with the oldest pending blurred pixel
		task check_result(input logic [PIX_W-1:0] pix, input logic done);
			blurred_t want;
			if (expected.size() == 0) begin
				report_mismatch($sformatf("unexpected result pixel %0d done %0b", pix, done));
				return;
			end
			want = expected.pop_front();
			if (pix !== want.pixel)
				report_mismatch($sformatf("pixel %0d, expected %0d", pix, want.pixel));
			if (done !== want.done)
				report_mismatch($sformatf("line_done %0b, expected %0b", done, want.done));
		endtask
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [RAD_W-1:0]     cfg_wdata     = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = '0;
	logic                 s_axis_tlast  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;
	logic                 m_axis_tlast;

	int                   send_idle_pct = 0;
	int                   recv_idle_pct = 0;
	int                   pixels_sent   = 0;
	int                   cycle_count   = 0;
	blur_scoreboard       board         = new();

	stack_blur_line #(
		.MAX_RADIUS(MAX_RAD)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	// clock
	always #HALF_PERIOD clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** stack_blur_line: FAILED **");
			$finish;
		end
	end

	// result side: check accepted results, stall at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tlast);
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// one pixel request, with random idle cycles ahead of it
	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_pixel(pix, last);
		pixels_sent++;
	endtask

	// sender holds off until every pending blurred pixel has come out
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected.size() != 0)
			@(posedge clk);
	endtask

	// radius write once the block has gone quiet
	task automatic write_radius(input logic [RAD_W-1:0] value);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_radius(value);
	endtask

	task automatic send_line(input logic [PIX_W-1:0] pixels [$]);
		foreach (pixels[i])
			send_pixel(pixels[i], i == pixels.size() - 1);
	endtask

	// extremes, pass-through, saturation, short lines, mid-line radius write
	task automatic run_directed();
		send_line('{8'hFF});
		write_radius('0);
		send_line('{8'h00, 8'hFF, 8'h80});
		write_radius('1);
		send_line('{8'hFF, 8'h00, 8'hFF, 8'h00});
		write_radius(RAD_W'(MAX_RAD));
		send_line('{8'h00});
		write_radius(RAD_W'(2));
		send_pixel(8'd10, 1'b0);
		write_radius(RAD_W'(5));
		send_line('{8'd200, 8'd30, 8'd77, 8'hFF});
		write_radius(RAD_W'(MAX_RAD + 1));
		send_line('{8'hFF, 8'hFF});
		write_radius(RAD_W'(1));
		send_line('{8'd1, 8'd2, 8'd3});
	endtask

	function automatic logic [RAD_W-1:0] pick_radius();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return RAD_W'(MAX_RAD);
			2: return '1;
			3: return RAD_W'($urandom_range(0, 63));
			default: return RAD_W'($urandom_range(1, 6));
		endcase
	endfunction

	// random line, biased toward the extreme pixel values
	task automatic send_random_line(input int len);
		logic [PIX_W-1:0] pix;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 7))
				0: pix = 8'h00;
				1: pix = 8'hFF;
				default: pix = PIX_W'($urandom_range(0, 255));
			endcase
			if (i > 0 && $urandom_range(0, 15) == 0)
				hold_until_drained();
			send_pixel(pix, i == len - 1);
		end
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct);
		int first;
		int r;
		int len;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		first         = pixels_sent;
		while (pixels_sent - first < PHASE_PIXELS) begin
			if ($urandom_range(0, 2) == 0)
				write_radius(pick_radius());
			r = (board.radius > MAX_RAD) ? MAX_RAD : board.radius;
			case ($urandom_range(0, 7))
				0: len = 1;
				1: len = $urandom_range(1, r + 1);
				default: len = $urandom_range(2, 2 * r + 12);
			endcase
			send_random_line(len);
		end
	endtask

	// main sequence
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 15;
		recv_idle_pct = 79;
		run_directed();
		run_random_phase(15, 79);
		run_random_phase(79, 15);
		run_random_phase(0, 0);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.expected.size() == 0)
			$display("** stack_blur_line: PASSED **");
		else
			$display("** stack_blur_line: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/sbl_pkg.sv
src/sbl_ram.sv
src/sbl_div.sv
src/sbl_ctrl.sv
src/sbl_dp.sv
src/stack_blur_line.sv
tb/tb_stack_blur_line.sv
